/* hw/rtl/mctw_pkg.sv */
package mctw_pkg;

    // Number of watchdog channels (1 to 8, as CH_W is 3).
    localparam int CHANNELS = 8;

    // Widths fixed by the interface fields.
    localparam int TMO_W = 16;
    localparam int CH_W  = 3;

    // Operation codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_FEED  = 2'd2
    } t_op;

    // Control state of the top level.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    // Tick token that moves down the chain of cells, one cell per cycle.
    typedef struct packed {
        logic            valid;
        logic            hit;
        logic [CH_W-1:0] idx;
    } t_token;

    // Start and feed command broadcast to every cell.
    typedef struct packed {
        logic start;
        logic feed;
    } t_cell_cmd;

endpackage

/* hw/rtl/multi_channel_task_watchdog_top.sv */
// Multi-channel task watchdog.
// Input channel (i_in_valid / o_in_stall) takes one word per operation:
// tick, start a channel with a timeout in ticks, or feed a channel.
// Output channel (o_out_valid / i_out_stall) returns one word per input
// word: accepted, tripped, hardware_feed, expired_flag, expired_channel.
// Start, feed, unused codes and a tick after a trip answer in the cycle
// after acceptance. A tick before a trip sends a token down the row of
// channel cells, one cell per cycle, and answers once the token leaves
// the last cell and the result word is registered.
// One word is worked on at a time: a new word is taken once the previous
// one is answered and the output register is free or being emptied.
// A timeout of zero expires after 65536 ticks.
// Reset idles every channel, clears the trip and empties the output.
// While the receiver stalls, the pending result holds and o_in_stall is
// raised, so no further word is taken.
module multi_channel_task_watchdog_top
    import mctw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_operation,
    input  logic [CH_W-1:0]  i_channel,
    input  logic [TMO_W-1:0] i_timeout_ticks,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_accepted,
    output logic             o_tripped,
    output logic             o_hardware_feed,
    output logic             o_expired_flag,
    output logic [CH_W-1:0]  o_expired_channel
);

    t_state           r_state;
    t_state           n_state;
    logic             r_trip;
    logic             n_trip;

    logic             r_out_valid;
    logic             r_accepted;
    logic             r_hw_feed;
    logic             r_exp_flag;
    logic [CH_W-1:0]  r_exp_ch;
    logic             n_out_valid;
    logic             n_accepted;
    logic             n_hw_feed;
    logic             n_exp_flag;
    logic [CH_W-1:0]  n_exp_ch;

    logic             w_in_acc;
    logic             w_out_taken;
    logic             w_tick_walk;
    t_cell_cmd        w_cmd;
    t_token           w_tok_head;
    t_token           w_tok [CHANNELS+1];
    logic [CHANNELS-1:0] w_sel;
    logic [CHANNELS-1:0] w_running;
    logic [CHANNELS-1:0] w_tok_valid;
    t_token           w_last;

    assign w_out_taken = r_out_valid && !i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_tick_walk = w_in_acc && (t_op'(i_operation) == OP_TICK) && !r_trip;
    assign w_last      = w_tok[CHANNELS];
    assign w_tok[0]    = w_tok_head;

    // Channel address decode; addresses at or above CHANNELS select nothing.
    for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
        assign w_sel[k] = ({{(32-CH_W){1'b0}}, i_channel} == 32'(k));

        mctw_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_index         (CH_W'(k)),
            .i_sel           (w_sel[k]),
            .i_cmd           (w_cmd),
            .i_timeout_ticks (i_timeout_ticks),
            .i_tok           (w_tok[k]),
            .o_tok           (w_tok[k+1]),
            .o_running       (w_running[k])
        );

        assign w_tok_valid[k] = w_tok[k+1].valid;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_tick_walk) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_last.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: stall, token injection and cell commands.
    always_comb begin
        o_in_stall = 1'b1;
        w_tok_head = '0;
        w_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall       = r_out_valid && i_out_stall;
                w_tok_head.valid = w_tick_walk;
                w_cmd.start      = w_in_acc && (t_op'(i_operation) == OP_START);
                w_cmd.feed       = w_in_acc && (t_op'(i_operation) == OP_FEED);
            end
            ST_WALK: begin
                o_in_stall = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Result word and trip latch.
    always_comb begin
        n_out_valid = r_out_valid && !w_out_taken;
        n_accepted  = r_accepted;
        n_hw_feed   = r_hw_feed;
        n_exp_flag  = r_exp_flag;
        n_exp_ch    = r_exp_ch;
        n_trip      = r_trip;
        if (w_last.valid) begin
            n_out_valid = 1'b1;
            n_accepted  = 1'b1;
            n_hw_feed   = !w_last.hit;
            n_exp_flag  = w_last.hit;
            n_exp_ch    = w_last.hit ? w_last.idx : '0;
            n_trip      = r_trip || w_last.hit;
        end else if (w_in_acc && !w_tick_walk) begin
            n_out_valid = 1'b1;
            n_hw_feed   = 1'b0;
            n_exp_flag  = 1'b0;
            n_exp_ch    = '0;
            case (t_op'(i_operation))
                OP_TICK:  n_accepted = 1'b1;
                OP_START: n_accepted = |(w_sel & ~w_running);
                OP_FEED:  n_accepted = |w_sel;
                default:  n_accepted = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_trip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_trip      <= n_trip;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        r_hw_feed  <= n_hw_feed;
        r_exp_flag <= n_exp_flag;
        r_exp_ch   <= n_exp_ch;
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_tripped         = r_trip;
    assign o_hardware_feed   = r_hw_feed;
    assign o_expired_flag    = r_exp_flag;
    assign o_expired_channel = r_exp_ch;

    // At most one tick token travels the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_valid) <= 1)
        else $error("more than one tick token in the cell chain");

    // A token only travels while the walk is in progress.
    a_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tok_valid != '0) |-> (r_state == ST_WALK))
        else $error("tick token outside a walk");

    // The trip is sticky until reset.
    a_trip_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trip |=> r_trip)
        else $error("trip cleared without reset");

    // An expiry report comes with the trip set and no hardware feed.
    a_expiry_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_expired_flag) |-> (o_tripped && !o_hardware_feed))
        else $error("expiry reported without trip or with hardware feed");

    // A finished walk always fills an empty output register.
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> !r_out_valid)
        else $error("walk finished while a result was still pending");

endmodule

/* hw/rtl/mctw_cell.sv */
module mctw_cell
    import mctw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CH_W-1:0]  i_index,
    input  logic             i_sel,
    input  t_cell_cmd        i_cmd,
    input  logic [TMO_W-1:0] i_timeout_ticks,
    input  t_token           i_tok,
    output t_token           o_tok,
    output logic             o_running
);

    logic             r_running;
    logic [TMO_W-1:0] r_remaining;
    logic [TMO_W-1:0] r_reload;
    t_token           r_tok;

    logic             n_running;
    logic [TMO_W-1:0] n_remaining;
    logic [TMO_W-1:0] n_reload;
    t_token           n_tok;

    logic [TMO_W-1:0] w_dec;
    logic             w_count;

    assign w_dec   = r_remaining - TMO_W'(1);
    assign w_count = i_tok.valid && !i_tok.hit && r_running;

    // Channel state: start arms an idle channel, feed reloads, a passing token counts down.
    always_comb begin
        n_running   = r_running;
        n_remaining = r_remaining;
        n_reload    = r_reload;
        if (i_cmd.start && i_sel && !r_running) begin
            n_running   = 1'b1;
            n_remaining = i_timeout_ticks;
            n_reload    = i_timeout_ticks;
        end else if (i_cmd.feed && i_sel) begin
            n_remaining = r_reload;
        end else if (w_count) begin
            n_remaining = w_dec;
        end
    end

    // The token carries the first expiry forward; later cells leave it alone.
    always_comb begin
        n_tok = i_tok;
        if (w_count && (w_dec == '0)) begin
            n_tok.hit = 1'b1;
            n_tok.idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_remaining <= '0;
            r_reload    <= '0;
            r_tok       <= '0;
        end else begin
            r_running   <= n_running;
            r_remaining <= n_remaining;
            r_reload    <= n_reload;
            r_tok       <= n_tok;
        end
    end

    assign o_tok     = r_tok;
    assign o_running = r_running;

endmodule
